/* hw/rtl/uer_pkg.sv */
// shared types, constants and register indexes of the ultrasonic echo ranger
package uer_pkg;

  localparam int PERIOD_BITS = 20;
  localparam int HALF_BITS = 8;
  localparam int HALF_COUNT_BITS = HALF_BITS + 1;
  localparam int PULSE_BITS = 4;
  localparam int DIST_BITS = 14;
  localparam int CFG_DATA_BITS = PERIOD_BITS;
  localparam int CFG_INDEX_BITS = 2;

  localparam int ECHO_COUNT_BITS_DEF = 16;

  // cm per tick is 17/1000, tracked as quotient and remainder
  localparam int TICK_CM_NUM = 17;
  localparam int TICK_CM_DEN = 1000;
  localparam int REM_BITS = $clog2(TICK_CM_DEN + TICK_CM_NUM);

  localparam logic [DIST_BITS-1:0] NO_ECHO_CM = DIST_BITS'(9999);

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(400000);
  localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(12);
  localparam logic [PULSE_BITS-1:0] PULSE_RESET = PULSE_BITS'(9);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PERIOD = 2'd0,
    REG_HALF_PULSE = 2'd1,
    REG_PULSE_COUNT = 2'd2
  } uer_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SEND = 3'b010,
    PH_MEASURE = 3'b100
  } uer_phase_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] period_ticks;
    logic [HALF_BITS-1:0] half_pulse_ticks;
    logic [PULSE_BITS-1:0] pulse_count;
  } uer_cfg_t;

  typedef struct packed {
    logic clear;
    logic inc;
  } uer_dist_ctl_t;

  typedef struct packed {
    logic tx_level;
    logic [DIST_BITS-1:0] distance_cm;
    logic new_result;
    logic timed_out;
  } uer_res_t;

endpackage

/* hw/rtl/uer_dist.sv */
// running distance: quotient and remainder of echo_count*17/1000, saturated
module uer_dist (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  uer_pkg::uer_dist_ctl_t           ctl,
  output logic [uer_pkg::DIST_BITS-1:0]    dist_cm
);

  logic [uer_pkg::DIST_BITS-1:0] quot;
  logic [uer_pkg::DIST_BITS-1:0] quot_next;
  logic [uer_pkg::REM_BITS-1:0]  rem;
  logic [uer_pkg::REM_BITS-1:0]  rem_next;
  logic [uer_pkg::REM_BITS-1:0]  rem_add;

  assign rem_add = rem + uer_pkg::REM_BITS'(uer_pkg::TICK_CM_NUM);

  always_comb begin
    quot_next = quot;
    rem_next = rem;
    if (ctl.clear) begin
      quot_next = '0;
      rem_next = '0;
    end else if (ctl.inc) begin
      if (rem_add >= uer_pkg::REM_BITS'(uer_pkg::TICK_CM_DEN)) begin
        rem_next = rem_add - uer_pkg::REM_BITS'(uer_pkg::TICK_CM_DEN);
        // hold at the no-echo value, same as min(floor, 9999)
        if (quot != uer_pkg::NO_ECHO_CM) begin
          quot_next = quot + uer_pkg::DIST_BITS'(1);
        end
      end else begin
        rem_next = rem_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quot <= '0;
      rem <= '0;
    end else if (step) begin
      quot <= quot_next;
      rem <= rem_next;
    end
  end

  assign dist_cm = quot;

endmodule

/* hw/rtl/uer_core.sv */
// per-tick sequencer: period trigger, pulse burst and echo timing
module uer_core #(
  parameter int ECHO_COUNT_BITS = uer_pkg::ECHO_COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          echo_level,
  input  uer_pkg::uer_cfg_t             cfg,
  input  logic [uer_pkg::DIST_BITS-1:0] dist_cm,
  output uer_pkg::uer_dist_ctl_t        dist_ctl,
  output uer_pkg::uer_res_t             res
);

  localparam logic [ECHO_COUNT_BITS-1:0] ECHO_TOP = '1;

  uer_pkg::uer_phase_t phase, phase_mid, phase_next;
  logic [uer_pkg::PERIOD_BITS-1:0]     period_count, period_count_next, period_inc;
  logic                                trigger_pending, trigger_pending_next, trig;
  logic [uer_pkg::PULSE_BITS-1:0]      pulses_left, pulses_mid, pulses_left_next;
  logic [uer_pkg::HALF_COUNT_BITS-1:0] half_count, half_mid, half_count_next, half_inc;
  logic [ECHO_COUNT_BITS-1:0]          echo_count, echo_count_next;
  logic [uer_pkg::DIST_BITS-1:0]       last_distance, last_distance_next;
  logic                                last_timeout, last_timeout_next;
  logic [uer_pkg::HALF_BITS-1:0]       half;
  logic                                tx, fresh;

  assign half = (cfg.half_pulse_ticks == '0) ? uer_pkg::HALF_BITS'(1) : cfg.half_pulse_ticks;
  assign period_inc = period_count + uer_pkg::PERIOD_BITS'(1);
  assign half_inc = half_mid + uer_pkg::HALF_COUNT_BITS'(1);

  always_comb begin
    trig = trigger_pending;
    period_count_next = period_inc;
    if (period_inc == cfg.period_ticks) begin
      period_count_next = '0;
      trig = 1'b1;
    end

    trigger_pending_next = trig;
    phase_mid = phase;
    pulses_mid = pulses_left;
    half_mid = half_count;
    echo_count_next = echo_count;
    last_distance_next = last_distance;
    last_timeout_next = last_timeout;
    dist_ctl = '0;
    fresh = 1'b0;
    tx = 1'b0;

    unique case (phase)
      uer_pkg::PH_MEASURE: begin
        if (!echo_level) begin
          last_distance_next = dist_cm;
          last_timeout_next = 1'b0;
          phase_mid = uer_pkg::PH_IDLE;
          echo_count_next = '0;
          dist_ctl.clear = 1'b1;
          fresh = 1'b1;
        end else if (echo_count == ECHO_TOP) begin
          last_distance_next = uer_pkg::NO_ECHO_CM;
          last_timeout_next = 1'b1;
          phase_mid = uer_pkg::PH_IDLE;
          echo_count_next = '0;
          dist_ctl.clear = 1'b1;
          fresh = 1'b1;
        end else begin
          echo_count_next = echo_count + ECHO_COUNT_BITS'(1);
          dist_ctl.inc = 1'b1;
        end
      end
      uer_pkg::PH_IDLE: begin
        if (trig) begin
          trigger_pending_next = 1'b0;
          pulses_mid = cfg.pulse_count;
          half_mid = '0;
          echo_count_next = '0;
          dist_ctl.clear = 1'b1;
          phase_mid = (cfg.pulse_count == '0) ? uer_pkg::PH_MEASURE : uer_pkg::PH_SEND;
        end
      end
      uer_pkg::PH_SEND: begin
      end
      default: begin
        phase_mid = uer_pkg::PH_IDLE;
      end
    endcase

    // burst output, taken on the same tick as the trigger
    phase_next = phase_mid;
    pulses_left_next = pulses_mid;
    half_count_next = half_mid;
    if (phase_mid == uer_pkg::PH_SEND) begin
      tx = (half_mid < {1'b0, half});
      half_count_next = half_inc;
      if (half_inc >= {half, 1'b0}) begin
        half_count_next = '0;
        pulses_left_next = pulses_mid - uer_pkg::PULSE_BITS'(1);
        if (pulses_left_next == '0) begin
          phase_next = uer_pkg::PH_MEASURE;
          echo_count_next = '0;
          dist_ctl.clear = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= uer_pkg::PH_IDLE;
      period_count <= '0;
      trigger_pending <= 1'b0;
      pulses_left <= '0;
      half_count <= '0;
      echo_count <= '0;
      last_distance <= '0;
      last_timeout <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      period_count <= period_count_next;
      trigger_pending <= trigger_pending_next;
      pulses_left <= pulses_left_next;
      half_count <= half_count_next;
      echo_count <= echo_count_next;
      last_distance <= last_distance_next;
      last_timeout <= last_timeout_next;
    end
  end

  assign res.tx_level = tx;
  assign res.distance_cm = last_distance_next;
  assign res.new_result = fresh;
  assign res.timed_out = last_timeout_next;

endmodule

/* hw/rtl/uer_obuf.sv */
// two-entry result buffer: output register plus skid entry
module uer_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  uer_pkg::uer_res_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output uer_pkg::uer_res_t out_data
);

  uer_pkg::uer_res_t main_data, skid_data;
  logic              main_valid, skid_valid;
  logic              pop;

  assign pop = main_valid && out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push && main_valid && !pop) begin
      skid_valid <= 1'b1;
    end else if (push) begin
      main_valid <= 1'b1;
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push && main_valid && !pop) begin
      skid_data <= push_data;
    end else if (push) begin
      main_data <= push_data;
    end
  end

  assign out_valid = main_valid;
  assign out_data = main_data;

endmodule

/* hw/rtl/ultrasonic_echo_ranger.sv */
// Ultrasonic echo ranger. Every echo beat is one 1 us tick and yields exactly one
// result beat. The tick's counters, burst state and the running distance quotient
// update when the beat is taken, and the result lands in a two-entry output
// buffer, so a new tick is taken in every cycle; echo_ready drops only while both
// buffer entries are held. Distance is floor(echo ticks * 17 / 1000) cm, kept as
// a quotient and remainder that step by 17 per echo tick, saturating at 9999;
// 9999 with timed_out set marks a counter overflow. Registers: 0 period_ticks,
// 1 half_pulse_ticks, 2 pulse_count.
module ultrasonic_echo_ranger #(
  parameter int ECHO_COUNT_BITS = uer_pkg::ECHO_COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [uer_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [uer_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               echo_valid,
  output logic                               echo_ready,
  input  logic                               echo_level,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic                               tx_level,
  output logic [uer_pkg::DIST_BITS-1:0]      distance_cm,
  output logic                               new_result,
  output logic                               timed_out
);

  uer_pkg::uer_cfg_t      cfg;
  uer_pkg::uer_dist_ctl_t dist_ctl;
  uer_pkg::uer_res_t      res, out_res;
  logic [uer_pkg::DIST_BITS-1:0] dist_cm;
  logic step;

  assign step = echo_valid && echo_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ticks <= uer_pkg::PERIOD_RESET;
      cfg.half_pulse_ticks <= uer_pkg::HALF_RESET;
      cfg.pulse_count <= uer_pkg::PULSE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uer_pkg::REG_PERIOD:      cfg.period_ticks <= cfg_data[uer_pkg::PERIOD_BITS-1:0];
        uer_pkg::REG_HALF_PULSE:  cfg.half_pulse_ticks <= cfg_data[uer_pkg::HALF_BITS-1:0];
        uer_pkg::REG_PULSE_COUNT: cfg.pulse_count <= cfg_data[uer_pkg::PULSE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  uer_core #(
    .ECHO_COUNT_BITS(ECHO_COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .echo_level (echo_level),
    .cfg        (cfg),
    .dist_cm    (dist_cm),
    .dist_ctl   (dist_ctl),
    .res        (res)
  );

  uer_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .ctl     (dist_ctl),
    .dist_cm (dist_cm)
  );

  uer_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (res),
    .space     (echo_ready),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (out_res)
  );

  assign tx_level = out_res.tx_level;
  assign distance_cm = out_res.distance_cm;
  assign new_result = out_res.new_result;
  assign timed_out = out_res.timed_out;

endmodule

/* hw/rtl/uer_checker.sv */
// port-level checks of the echo ranger, bound to the top level
module uer_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          echo_valid,
  input logic                          echo_ready,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic                          tx_level,
  input logic [uer_pkg::DIST_BITS-1:0] distance_cm,
  input logic                          new_result,
  input logic                          timed_out
);

  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat dropped while stalled");

  // every accepted echo beat is followed by an offered result beat next cycle
  a_pass: assert property (@(posedge clk) disable iff (rst)
    echo_valid && echo_ready |=> result_valid)
    else $error("accepted tick produced no result beat");

  // input stalls only when results are backed up
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !echo_ready |-> result_valid)
    else $error("echo_ready low with no pending result");

  // overflow always reports the no-echo distance
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    result_valid && timed_out |-> distance_cm == uer_pkg::NO_ECHO_CM)
    else $error("timed_out without no-echo distance");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(tx_level && new_result))
    else $error("measurement finished during a transmit pulse");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk          (clk),
  .rst          (rst),
  .echo_valid   (echo_valid),
  .echo_ready   (echo_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .tx_level     (tx_level),
  .distance_cm  (distance_cm),
  .new_result   (new_result),
  .timed_out    (timed_out)
);

/* tb/ultrasonic_echo_ranger_check.sv */
// tick-by-tick predictor and result checker for the ultrasonic echo ranger
module ultrasonic_echo_ranger_check
  import uer_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      echo_valid,
  input  logic                      echo_ready,
  input  logic                      echo_level,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  logic                      tx_level,
  input  logic [DIST_BITS-1:0]      distance_cm,
  input  logic                      new_result,
  input  logic                      timed_out,
  output int                        mismatches,
  output int                        ticks_pending
);

  localparam int ECHO_BITS = ECHO_COUNT_BITS_DEF;

  uer_cfg_t                   cfg;
  uer_phase_t                 phase;
  logic [PERIOD_BITS-1:0]     period_cnt;
  logic                       trig_pend;
  logic [PULSE_BITS-1:0]      pulses_left;
  logic [HALF_COUNT_BITS-1:0] half_cnt;
  logic [ECHO_BITS-1:0]       echo_cnt;
  logic [DIST_BITS-1:0]       last_dist;
  logic                       last_tmo;

  uer_res_t tick_results_q[$];

  task automatic end_measure(input logic [DIST_BITS-1:0] dist_cm, input logic tmo);
    last_dist = dist_cm;
    last_tmo = tmo;
    phase = PH_IDLE;
    echo_cnt = '0;
  endtask

  // one timebase tick of the ranger, returns the result beat it yields
  task automatic ranger_tick(input logic echo, output uer_res_t r);
    int half;
    int calc_cm;
    r = '0;
    half = (cfg.half_pulse_ticks == '0) ? 1 : int'(cfg.half_pulse_ticks);

    period_cnt = period_cnt + PERIOD_BITS'(1);
    if (period_cnt == cfg.period_ticks) begin
      period_cnt = '0;
      trig_pend = 1'b1;
    end

    if (phase == PH_MEASURE) begin
      if (!echo) begin
        calc_cm = int'(echo_cnt) * TICK_CM_NUM / TICK_CM_DEN;
        if (calc_cm > int'(NO_ECHO_CM)) calc_cm = int'(NO_ECHO_CM);
        end_measure(DIST_BITS'(calc_cm), 1'b0);
        r.new_result = 1'b1;
      end else if (echo_cnt == '1) begin
        end_measure(NO_ECHO_CM, 1'b1);
        r.new_result = 1'b1;
      end else begin
        echo_cnt = echo_cnt + ECHO_BITS'(1);
      end
    end else if (phase != PH_SEND) begin
      phase = PH_IDLE;
      if (trig_pend) begin
        trig_pend = 1'b0;
        pulses_left = cfg.pulse_count;
        half_cnt = '0;
        echo_cnt = '0;
        phase = (pulses_left == '0) ? PH_MEASURE : PH_SEND;
      end
    end

    // burst started this tick transmits on this tick
    if (phase == PH_SEND) begin
      r.tx_level = (int'(half_cnt) < half);
      half_cnt = half_cnt + HALF_COUNT_BITS'(1);
      if (int'(half_cnt) >= 2 * half) begin
        half_cnt = '0;
        pulses_left = pulses_left - PULSE_BITS'(1);
        if (pulses_left == '0) begin
          phase = PH_MEASURE;
          echo_cnt = '0;
        end
      end
    end

    r.distance_cm = last_dist;
    r.timed_out = last_tmo;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("mismatch %s: expected %0d, got %0d at %0t", name, want, got, $realtime);
      mismatches = mismatches + 1;
    end
  endtask

  always @(posedge clk) begin
    uer_res_t want;
    if (rst) begin
      cfg = '{period_ticks: PERIOD_RESET, half_pulse_ticks: HALF_RESET,
              pulse_count: PULSE_RESET};
      phase = PH_IDLE;
      period_cnt = '0;
      trig_pend = 1'b0;
      pulses_left = '0;
      half_cnt = '0;
      echo_cnt = '0;
      last_dist = '0;
      last_tmo = 1'b0;
      mismatches = 0;
      tick_results_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_PERIOD)
          cfg.period_ticks = cfg_data;
        else if (cfg_index == REG_HALF_PULSE)
          cfg.half_pulse_ticks = cfg_data[HALF_BITS-1:0];
        else if (cfg_index == REG_PULSE_COUNT)
          cfg.pulse_count = cfg_data[PULSE_BITS-1:0];
      end

      if (echo_valid && echo_ready) begin
        ranger_tick(echo_level, want);
        tick_results_q.push_back(want);
      end

      if (result_valid && result_ready) begin
        if (tick_results_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result beat at %0t", $realtime);
          mismatches = mismatches + 1;
        end else begin
          want = tick_results_q.pop_front();
          check_field("tx_level", 32'(want.tx_level), 32'(tx_level));
          check_field("distance_cm", 32'(want.distance_cm), 32'(distance_cm));
          check_field("new_result", 32'(want.new_result), 32'(new_result));
          check_field("timed_out", 32'(want.timed_out), 32'(timed_out));
        end
      end
    end
    ticks_pending <= tick_results_q.size();
  end

endmodule

/* tb/ultrasonic_echo_ranger_test.sv */
// top of the ultrasonic echo ranger testbench: clock, reset, stimulus and verdict
module ultrasonic_echo_ranger_test;
  import uer_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int LONG_HOLD = 60;
  localparam int LIMIT_CYCLES = 20_000_000;
  localparam logic [13:0] DIRECTED_ECHO = 14'b01101000110100;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      echo_valid;
  logic                      echo_ready;
  logic                      echo_level;
  logic                      result_valid;
  logic                      result_ready;
  logic                      tx_level;
  logic [DIST_BITS-1:0]      distance_cm;
  logic                      new_result;
  logic                      timed_out;

  int mismatches;
  int ticks_pending;
  bit idle_on = 1'b1;
  bit hold_long = 1'b0;

  ultrasonic_echo_ranger u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .echo_valid(echo_valid), .echo_ready(echo_ready), .echo_level(echo_level),
    .result_valid(result_valid), .result_ready(result_ready),
    .tx_level(tx_level), .distance_cm(distance_cm),
    .new_result(new_result), .timed_out(timed_out)
  );

  ultrasonic_echo_ranger_check u_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .echo_valid(echo_valid), .echo_ready(echo_ready), .echo_level(echo_level),
    .result_valid(result_valid), .result_ready(result_ready),
    .tx_level(tx_level), .distance_cm(distance_cm),
    .new_result(new_result), .timed_out(timed_out),
    .mismatches(mismatches), .ticks_pending(ticks_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 4);
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long && !hold_done) begin
        hold_done = 1'b1;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        result_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // offer one tick beat; ready is looked at mid-cycle, the beat goes at the next edge
  task automatic send_tick(input logic lvl);
    echo_valid <= 1'b1;
    echo_level <= lvl;
    @(negedge clk);
    while (!echo_ready) @(negedge clk);
    @(posedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      echo_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_echo_run(input int high_len, input int low_len);
    repeat (high_len) send_tick(1'b1);
    repeat (low_len) send_tick(1'b0);
  endtask

  task automatic wait_quiet();
    echo_valid <= 1'b0;
    @(negedge clk);
    while (ticks_pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [CFG_DATA_BITS-1:0] period,
                             input logic [CFG_DATA_BITS-1:0] half,
                             input logic [CFG_DATA_BITS-1:0] pulses,
                             input bit touch_unused);
    wait_quiet();
    write_reg(REG_PERIOD, period);
    write_reg(REG_HALF_PULSE, half);
    write_reg(REG_PULSE_COUNT, pulses);
    if (touch_unused) write_reg(REG_UNUSED, 20'hFFFFF);
    cfg_we <= 1'b0;
  endtask

  // mostly echo-high runs closed by one to four low ticks, with some single random ticks as noise
  task automatic random_phase(input int n_ticks);
    int sent;
    int hi;
    int lo;
    sent = 0;
    while (sent < n_ticks) begin
      if ($urandom_range(0, 7) == 0) begin
        send_tick($urandom_range(0, 1) == 1);
        sent = sent + 1;
      end else begin
        hi = $urandom_range(0, 60);
        lo = $urandom_range(1, 4);
        send_echo_run(hi, lo);
        sent = sent + hi + lo;
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_PERIOD;
    cfg_data <= '0;
    echo_valid <= 1'b0;
    echo_level <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_echo_run(3, 3);

    // trigger every tick, zero half pulse, no pulses: measuring starts right away
    reconfigure(20'd1, 20'd0, 20'd0, 1'b1);
    for (int i = 0; i < 14; i++) send_tick(DIRECTED_ECHO[i]);

    // wrapping period and the widest period
    reconfigure(20'd0, 20'd1, 20'd1, 1'b0);
    send_echo_run(2, 1);
    reconfigure(20'hFFFFF, 20'd1, 20'd1, 1'b0);
    send_echo_run(2, 1);

    // bits above each register's width are dropped
    reconfigure(20'd40, 20'hABC03, 20'h5F0F3, 1'b0);
    random_phase(60);

    // half pulse past 255 counts per period, with triggers arriving while busy
    reconfigure(20'd1, 20'd130, 20'd1, 1'b0);
    send_echo_run(262, 2);

    // two long echoes for larger distances
    reconfigure(20'd50, 20'd1, 20'd1, 1'b0);
    repeat (2) send_echo_run($urandom_range(60, 100), 2);

    for (int k = 0; k < 6; k++) begin
      reconfigure(CFG_DATA_BITS'($urandom_range(1, 300)),
                  CFG_DATA_BITS'($urandom_range(0, 6)),
                  CFG_DATA_BITS'($urandom_range(0, 5)), 1'b0);
      // results back up until the input stalls
      if (k == 2) hold_long = 1'b1;
      random_phase(30);
    end

    idle_on = 1'b0;
    reconfigure(20'd7, 20'd2, 20'd2, 1'b0);
    random_phase(40);

    wait_quiet();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
